// File: src/tmcw_pkg.sv
// Shared constants, types and command/status structs for the text-mode character writer.
package tmcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;
  localparam int unsigned MOVE_CELLS = (ROWS - 2) * COLUMNS;
  localparam int unsigned FILL_END   = (ROWS - 1) * COLUMNS;

  localparam int unsigned ADDR_W = $clog2(CELL_COUNT);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);

  localparam int unsigned OP_W     = 1;
  localparam int unsigned CHAR_W   = 9;
  localparam int unsigned INDEX_W  = 11;
  localparam int unsigned CURSOR_W = 11;
  localparam int unsigned VALUE_W  = 16;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COL_W-1:0]   col_t;
  typedef logic [VALUE_W-1:0] cell_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 9'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 9'h100;
  localparam logic [7:0]        ATTR_NORMAL    = 8'h07;
  localparam cell_t             BLANK_CELL     = 16'h0720;

  localparam row_t  LAST_ROW    = row_t'(ROWS - 1);
  localparam row_t  SCROLL_ROW  = row_t'(ROWS - 2);
  localparam col_t  LAST_COL    = col_t'(COLUMNS - 1);
  localparam addr_t COLS_A      = addr_t'(COLUMNS);
  localparam addr_t CLEAR_LAST  = addr_t'(CELL_COUNT - 1);
  localparam addr_t MOVE_A      = addr_t'(MOVE_CELLS);
  localparam addr_t FILL_LAST   = addr_t'(FILL_END - 1);

  // controller -> datapath
  typedef struct packed {
    logic clear;        // reset clearing pass: zero at counter
    logic accept_put;   // take a put word, write character, step cursor
    logic accept_read;  // take a read word, issue RAM read
    logic copy;         // scroll: move one cell up a row
    logic fill;         // scroll: zero tail of the row under the cursor
    logic blank;        // blank under cursor, load put result
    logic read_out;     // load read result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scroll;
    logic clear_last;
    logic copy_last;
    logic fill_last;
  } dp_status_t;

endpackage

// File: src/tmcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tmcw_ctrl.sv
// Controller state machine: sequences clearing, put, scroll and read work.
module tmcw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic [tmcw_pkg::OP_W-1:0] operation_i,
  input  tmcw_pkg::dp_status_t   status_i,
  output logic                   busy,
  output logic                   done_o,
  output tmcw_pkg::dp_cmd_t      cmd_o
);
  import tmcw_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_COPY   = 6'b000100,
    S_FILL   = 6'b001000,
    S_BLANK  = 6'b010000,
    S_RDWAIT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (op_e'(operation_i) == OP_READ) begin
            cmd_o.accept_read = 1'b1;
            state_d           = S_RDWAIT;
          end else begin
            cmd_o.accept_put = 1'b1;
            state_d          = status_i.scroll ? S_COPY : S_BLANK;
          end
        end
      end
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (status_i.copy_last) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (status_i.fill_last) begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        cmd_o.blank = 1'b1;
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end
      S_RDWAIT: begin
        cmd_o.read_out = 1'b1;
        done_d         = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: src/tmcw_dp.sv
// Datapath: cursor registers, screen RAM, sweep counter and result registers.
module tmcw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tmcw_pkg::dp_cmd_t             cmd_i,
  input  logic [tmcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tmcw_pkg::INDEX_W-1:0]  cell_index_i,
  output tmcw_pkg::dp_status_t          status_o,
  output logic [tmcw_pkg::CURSOR_W-1:0] cursor_position_o,
  output logic [tmcw_pkg::VALUE_W-1:0]  cell_value_o
);
  import tmcw_pkg::*;

  row_t  row_q, row_d;
  col_t  col_q, col_d;
  addr_t cur_q, cur_d;
  addr_t cnt_q, cnt_d;
  logic  in_range_q;
  logic [CURSOR_W-1:0] res_cursor_q;
  cell_t               res_value_q;

  row_t  row_a;
  col_t  col_a;
  addr_t cur_a;
  logic  is_nl, is_bs, scroll;

  logic  we;
  addr_t waddr, raddr;
  cell_t wdata, rdata;
  logic  copy_rd, copy_wr;

  // next cursor for a put word
  always_comb begin
    is_nl = (char_code_i == CODE_NEWLINE);
    is_bs = (char_code_i == CODE_BACKSPACE);
    row_a = row_q;
    col_a = col_q;
    cur_a = cur_q;
    if (is_nl) begin
      row_a = row_q + row_t'(1);
      col_a = '0;
      cur_a = cur_q + COLS_A - addr_t'(col_q);
    end else if (is_bs) begin
      if (cur_q != '0) begin
        cur_a = cur_q - addr_t'(1);
        if (col_q == '0) begin
          col_a = LAST_COL;
          row_a = row_q - row_t'(1);
        end else begin
          col_a = col_q - col_t'(1);
        end
      end
    end else begin
      cur_a = cur_q + addr_t'(1);
      if (col_q == LAST_COL) begin
        col_a = '0;
        row_a = row_q + row_t'(1);
      end else begin
        col_a = col_q + col_t'(1);
      end
    end
    scroll = (row_a == LAST_ROW);
  end

  assign copy_rd = cmd_i.copy && (cnt_q < MOVE_A);
  assign copy_wr = cmd_i.copy && (cnt_q != '0);

  // RAM port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = '0;
    raddr = addr_t'(cell_index_i);
    if (cmd_i.clear || cmd_i.fill) begin
      we = 1'b1;
    end else if (copy_wr) begin
      we    = 1'b1;
      waddr = cnt_q - addr_t'(1);
      wdata = rdata;
    end else if (cmd_i.accept_put) begin
      we    = !is_nl && !is_bs;
      waddr = cur_q;
      wdata = {ATTR_NORMAL, char_code_i[7:0]};
    end else if (cmd_i.blank) begin
      we    = 1'b1;
      waddr = cur_q;
      wdata = BLANK_CELL;
    end
    if (copy_rd) begin
      raddr = cnt_q + COLS_A;
    end
  end

  tmcw_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    cur_d = cur_q;
    cnt_d = cnt_q;
    if (cmd_i.accept_put) begin
      col_d = col_a;
      cnt_d = '0;
      if (scroll) begin
        row_d = SCROLL_ROW;
        cur_d = cur_a - COLS_A;
      end else begin
        row_d = row_a;
        cur_d = cur_a;
      end
    end else if (cmd_i.copy) begin
      // tail clear starts at the cursor once the move is done
      cnt_d = (cnt_q == MOVE_A) ? cur_q : cnt_q + addr_t'(1);
    end else if (cmd_i.clear || cmd_i.fill) begin
      cnt_d = cnt_q + addr_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      cur_q <= '0;
      cnt_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      cur_q <= cur_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_read) begin
      in_range_q <= (32'(cell_index_i) < 32'(CELL_COUNT));
    end
    if (cmd_i.blank || cmd_i.read_out) begin
      res_cursor_q <= CURSOR_W'(cur_q);
      res_value_q  <= (cmd_i.read_out && in_range_q) ? rdata : '0;
    end
  end

  assign status_o.scroll     = scroll;
  assign status_o.clear_last = (cnt_q == CLEAR_LAST);
  assign status_o.copy_last  = (cnt_q == MOVE_A);
  assign status_o.fill_last  = (cnt_q == FILL_LAST);

  assign cursor_position_o = res_cursor_q;
  assign cell_value_o      = res_value_q;

endmodule

// File: src/text_mode_character_writer.sv
// Top level of the text-mode character writer: controller plus datapath.
//
// Usage: present a word on operation_i/char_code_i/cell_index_i with start high;
// it is taken at the clock edge where start is high and busy is low.
// Every word gives one result: done_o is high for exactly one cycle with
// cursor_position_o and cell_value_o valid. The receiver cannot stall; the
// result must be taken in that cycle.
// Sequencing: a read passes through the read-wait state and a put that does
// not scroll through the blank state, and the result is registered from there;
// busy is high until then, so a new word is taken no earlier than the cycle in
// which the previous result is shown. A put that moves the cursor into the last
// row scrolls the screen: the screen RAM's single read and write port moves
// (ROWS-2)*COLUMNS cells up a row, then zeroes the COLUMNS cells of row ROWS-2.
// Reset: the cursor returns to zero and a clearing pass writes zero to all
// COLUMNS*ROWS (2000) cells, one a cycle; busy stays high for those cycles.
module text_mode_character_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [tmcw_pkg::OP_W-1:0]     operation_i,
  input  logic [tmcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tmcw_pkg::INDEX_W-1:0]  cell_index_i,
  output logic                          done_o,
  output logic [tmcw_pkg::CURSOR_W-1:0] cursor_position_o,
  output logic [tmcw_pkg::VALUE_W-1:0]  cell_value_o
);
  import tmcw_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  tmcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .status_i    (status),
    .busy        (busy),
    .done_o      (done_o),
    .cmd_o       (cmd)
  );

  tmcw_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .status_o          (status),
    .cursor_position_o (cursor_position_o),
    .cell_value_o      (cell_value_o)
  );

endmodule

// File: src/tmcw_checker.sv
// Port-level checker for the text-mode character writer, bound to the top level.
module tmcw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic [tmcw_pkg::OP_W-1:0]     operation_i,
  input logic                          done_o
);
  import tmcw_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // a taken word always occupies the block for at least the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block idle right after taking a word");

  // a taken read delivers its result strobe after the read-wait state
  a_read_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_e'(operation_i) == OP_READ)) |-> ##2 done_o)
    else $error("read result not delivered on time");

  // results are shown only once the block is free again
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // never two result strobes back to back
  a_done_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

endmodule

bind text_mode_character_writer tmcw_checker u_tmcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .operation_i (operation_i),
  .done_o      (done_o)
);
